>>> design/sdpd_pkg.sv
// Shared constants, types and address helper for the sync header deframer.
package sdpd_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int HDR_BYTES   = 4;
  localparam int STORE_DEPTH = MAX_PAYLOAD + HDR_BYTES + 1;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CW          = $clog2(STORE_DEPTH + 1);

  localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } sdpd_word_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
  } sdpd_cfg_t;

  typedef struct packed {
    logic [CW-1:0] fill;
    logic          busy;
  } sdpd_status_t;

  // (a + b) modulo the store depth, for a < depth and b <= depth
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + (AW + 1)'(b);
    if (s >= (AW + 1)'(STORE_DEPTH)) s = s - (AW + 1)'(STORE_DEPTH);
    return s[AW-1:0];
  endfunction

endpackage

>>> design/sdpd_ram.sv
// Generic single write port, single read port RAM with registered read.
module sdpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> design/sdpd_front.sv
// Input side: two-word queue of received bytes ahead of the parser.
module sdpd_front import sdpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] data_i,
  output logic       full_o,
  output sdpd_word_t word_o,
  input  logic       pop_i
);
  logic [7:0] buf_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign word_o.valid = (cnt_q != 2'd0);
  assign word_o.data  = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) buf_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

>>> design/sdpd_engine.sv
// Back side: frame store, header/checksum sequencer and result register.
module sdpd_engine import sdpd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  sdpd_cfg_t    cfg_i,
  input  sdpd_word_t   word_i,
  output logic         pop_o,
  output logic         empty_o,
  input  logic         pop_i,
  output logic [7:0]   command_o,
  output logic [5:0]   payload_length_o,
  output logic [7:0]   payload_byte_o,
  output logic [4:0]   byte_index_o,
  output logic         has_payload_o,
  output logic         frame_end_o,
  output sdpd_status_t status_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_H0, S_H0D, S_H1, S_H1D, S_H3, S_H3D, S_SUM, S_SUMD,
    S_CMD, S_CMDD, S_PL, S_PLD, S_EMIT, S_RA, S_RAD
  } state_e;

  state_e        state_q;
  logic [AW-1:0] head_q;
  logic [CW-1:0] cnt_q, off_q;
  logic [5:0]    len_q, idx_q;
  logic [7:0]    sum_q, cmd_q, data_q;
  logic          ovld_q;
  logic [7:0]    rdata;
  logic          we, slot_free, last, fire;
  logic [CW-1:0] total;

  assign we        = (state_q == S_IDLE) && word_i.valid && (cnt_q < CW'(STORE_DEPTH));
  assign pop_o     = (state_q == S_IDLE) && word_i.valid;
  assign slot_free = !ovld_q || pop_i;
  assign fire      = (state_q == S_EMIT) && slot_free;
  assign total     = CW'(len_q) + CW'(HDR_BYTES + 1);
  assign last      = (len_q == 6'd0) || (idx_q + 6'd1 == len_q);
  assign empty_o   = !ovld_q;
  assign status_o.fill = cnt_q;
  assign status_o.busy = (state_q != S_IDLE);

  sdpd_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wrap_add(head_q, cnt_q)),
    .wdata_i (word_i.data),
    .raddr_i (wrap_add(head_q, off_q)),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      head_q           <= '0;
      cnt_q            <= '0;
      off_q            <= '0;
      ovld_q           <= 1'b0;
      len_q            <= '0;
      idx_q            <= '0;
      sum_q            <= '0;
      cmd_q            <= '0;
      data_q           <= '0;
      command_o        <= '0;
      payload_length_o <= '0;
      payload_byte_o   <= '0;
      byte_index_o     <= '0;
      has_payload_o    <= 1'b0;
      frame_end_o      <= 1'b0;
    end else begin
      ovld_q <= fire || (ovld_q && !pop_i);
      unique case (state_q)
        S_IDLE: begin
          if (word_i.valid) begin
            if (we) cnt_q <= cnt_q + CW'(1);
            off_q   <= '0;
            state_q <= S_H0;
          end
        end
        S_H0: state_q <= (cnt_q == '0) ? S_IDLE : S_H0D;
        S_H0D: begin
          off_q <= CW'(1);
          if (rdata != cfg_i.sync_first) state_q <= S_RA;
          else if (cnt_q < CW'(2))       state_q <= S_IDLE;
          else                           state_q <= S_H1;
        end
        S_H1: state_q <= S_H1D;
        S_H1D: begin
          if (rdata != cfg_i.sync_second) begin
            off_q   <= CW'(1);
            state_q <= S_RA;
          end else if (cnt_q < CW'(HDR_BYTES)) begin
            state_q <= S_IDLE;
          end else begin
            off_q   <= CW'(3);
            state_q <= S_H3;
          end
        end
        S_H3: state_q <= S_H3D;
        S_H3D: begin
          if (rdata > 8'(MAX_PAYLOAD)) begin
            off_q   <= CW'(1);
            state_q <= S_RA;
          end else if (cnt_q < CW'(rdata[5:0]) + CW'(HDR_BYTES + 1)) begin
            state_q <= S_IDLE;
          end else begin
            len_q   <= rdata[5:0];
            off_q   <= '0;
            sum_q   <= '0;
            state_q <= S_SUM;
          end
        end
        S_SUM: state_q <= S_SUMD;
        S_SUMD: begin
          if (off_q == total - CW'(1)) begin
            if (sum_q == rdata) begin
              off_q   <= CW'(2);
              state_q <= S_CMD;
            end else begin
              off_q   <= CW'(1);
              state_q <= S_RA;
            end
          end else begin
            sum_q   <= sum_q + rdata;
            off_q   <= off_q + CW'(1);
            state_q <= S_SUM;
          end
        end
        S_CMD: state_q <= S_CMDD;
        S_CMDD: begin
          cmd_q   <= rdata;
          off_q   <= CW'(HDR_BYTES);
          idx_q   <= '0;
          data_q  <= '0;
          state_q <= (len_q == 6'd0) ? S_EMIT : S_PL;
        end
        S_PL: state_q <= S_PLD;
        S_PLD: begin
          data_q  <= rdata;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            command_o        <= cmd_q;
            payload_length_o <= len_q;
            payload_byte_o   <= data_q;
            byte_index_o     <= idx_q[4:0];
            has_payload_o    <= (len_q != 6'd0);
            frame_end_o      <= last;
            if (last) begin
              head_q  <= wrap_add(head_q, total);
              cnt_q   <= cnt_q - total;
              off_q   <= '0;
              state_q <= S_H0;
            end else begin
              idx_q   <= idx_q + 6'd1;
              off_q   <= off_q + CW'(1);
              state_q <= S_PL;
            end
          end
        end
        // scan for the next sync_first, starting just past the front byte
        S_RA: begin
          if (off_q >= cnt_q) begin
            cnt_q   <= '0;
            off_q   <= '0;
            state_q <= S_H0;
          end else begin
            state_q <= S_RAD;
          end
        end
        S_RAD: begin
          if (rdata == cfg_i.sync_first) begin
            head_q  <= wrap_add(head_q, off_q);
            cnt_q   <= cnt_q - off_q;
            off_q   <= '0;
            state_q <= S_H0;
          end else begin
            off_q   <= off_q + CW'(1);
            state_q <= S_RA;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> design/sync_header_packet_deframer.sv
// Top level: config registers, input queue and frame parser of the deframer.
// Flow: the parser takes a new byte only while idle, so the input queue stalls while it
// checks a frame or scans; a frame check reads up to 37 stored bytes, a resync scan reads
// the stored bytes one by one, and payload words wait while the result register is full.
// Reset: async low; store empty, sync bytes 0x55/0xAA, queues empty, no clearing pass.
module sync_header_packet_deframer import sdpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  command_o,
  output logic [5:0]  payload_length_o,
  output logic [7:0]  payload_byte_o,
  output logic [4:0]  byte_index_o,
  output logic        has_payload_o,
  output logic        frame_end_o
);
  sdpd_cfg_t    cfg_q;
  sdpd_word_t   word;
  sdpd_status_t status;
  logic         eng_pop, cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // register index is paddr[2]; byte lanes below it are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SYNC_FIRST:  cfg_q.sync_first  <= pwdata[7:0];
        REG_SYNC_SECOND: cfg_q.sync_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SYNC_FIRST:  prdata = {24'd0, cfg_q.sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, cfg_q.sync_second};
      default:         prdata = '0;
    endcase
  end

  // front: buffers received words so the parser can stall on its own
  sdpd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (rx_byte_i),
    .full_o (full),
    .word_o (word),
    .pop_i  (eng_pop)
  );

  // back: frame store, parsing and the result register
  sdpd_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .word_i           (word),
    .pop_o            (eng_pop),
    .empty_o          (empty),
    .pop_i            (pop),
    .command_o        (command_o),
    .payload_length_o (payload_length_o),
    .payload_byte_o   (payload_byte_o),
    .byte_index_o     (byte_index_o),
    .has_payload_o    (has_payload_o),
    .frame_end_o      (frame_end_o),
    .status_o         (status)
  );

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.fill <= CW'(STORE_DEPTH))
    else $error("frame store fill above depth");

  a_marker_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_payload_o) |-> (frame_end_o && payload_length_o == 6'd0))
    else $error("empty-frame marker malformed");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && has_payload_o) |->
      ({1'b0, byte_index_o} < payload_length_o &&
       payload_length_o <= 6'(MAX_PAYLOAD)))
    else $error("payload index out of range");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_pop |-> !status.busy)
    else $error("parser took a word while busy");
endmodule
